[rtl/core/ght_pkg.sv]
// Shared types and constants of the generational handle table.
package ght_pkg;

    localparam int KIND_W  = 3;
    localparam int OP_W    = 2;
    localparam int IDL_W   = 12;
    localparam int CAP_W   = 11;
    localparam int NUM_CAPS = 5;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOK = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

    localparam logic [2:0] REG_ID_LIMIT = 3'd0;
    localparam logic [2:0] REG_CAP0     = 3'd1;
    localparam logic [2:0] REG_CAP1     = 3'd2;
    localparam logic [2:0] REG_CAP2     = 3'd3;
    localparam logic [2:0] REG_CAP3     = 3'd4;
    localparam logic [2:0] REG_CAP4     = 3'd5;

    localparam logic [IDL_W-1:0] RST_ID_LIMIT = 12'd2000;
    localparam logic [CAP_W-1:0] RST_CAP [NUM_CAPS] = '{
        11'd10, 11'd1000, 11'd200, 11'd10, 11'd10
    };

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_ID      = 3'd1,
        ST_KIND_FULL  = 3'd2,
        ST_BAD        = 3'd3,
        ST_STACK_FULL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_ADD
    } t_state;

    typedef struct packed {
        logic is_add;
        logic is_del;
        logic is_look;
        logic kind_ok;
        logic id_ok;
    } t_cls;

endpackage

[rtl/core/ght_front.sv]
// Request intake: registers a beat and classifies opcode, kind and id range.
module ght_front #(
    parameter int ID_W,
    parameter int GEN_BITS,
    parameter int NUM_KINDS,
    parameter int LW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ght_pkg::OP_W-1:0]      i_opcode,
    input  logic [ght_pkg::KIND_W-1:0]    i_kind,
    input  logic [ID_W-1:0]               i_req_id,
    input  logic [GEN_BITS-1:0]           i_req_gen,
    input  logic [LW-1:0]                 i_lim,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ght_pkg::t_cls                 o_cls,
    output logic [ght_pkg::KIND_W-1:0]    o_kind,
    output logic [ID_W-1:0]               o_id,
    output logic [GEN_BITS-1:0]           o_gen
);

    logic          r_valid;
    ght_pkg::t_cls r_cls;
    ght_pkg::t_cls n_cls;
    logic [ght_pkg::KIND_W-1:0] r_kind;
    logic [ID_W-1:0]            r_id;
    logic [GEN_BITS-1:0]        r_gen;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_cls = '0;
        unique case (i_opcode)
            ght_pkg::OP_ADD:  n_cls.is_add  = 1'b1;
            ght_pkg::OP_DEL:  n_cls.is_del  = 1'b1;
            ght_pkg::OP_LOOK: n_cls.is_look = 1'b1;
            default:          n_cls.is_add  = 1'b0;
        endcase
        n_cls.kind_ok = ({1'b0, i_kind} < (ght_pkg::KIND_W + 1)'(NUM_KINDS));
        n_cls.id_ok   = (LW'(i_req_id) < i_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cls  <= n_cls;
            r_kind <= i_kind;
            r_id   <= i_req_id;
            r_gen  <= i_req_gen;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;
    assign o_kind  = r_kind;
    assign o_id    = r_id;
    assign o_gen   = r_gen;

endmodule

[rtl/core/ght_fifo.sv]
// Two-entry queue between the intake and the execution sequencer.
module ght_fifo #(
    parameter int W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/core/ght_back.sv]
// Execution sequencer: slot, position, dense and free-stack memories and result register.
module ght_back #(
    parameter int MAX_IDS,
    parameter int FREE_DEPTH,
    parameter int KIND_DEPTH,
    parameter int GEN_BITS,
    parameter int NUM_KINDS,
    parameter int LW,
    localparam int ID_W  = $clog2(MAX_IDS),
    localparam int POS_W = $clog2(KIND_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [LW-1:0]                 i_lim,
    input  logic [ght_pkg::CAP_W-1:0]     i_cap [ght_pkg::NUM_CAPS],
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  ght_pkg::t_cls                 i_q_cls,
    input  logic [ght_pkg::KIND_W-1:0]    i_q_kind,
    input  logic [ID_W-1:0]               i_q_id,
    input  logic [GEN_BITS-1:0]           i_q_gen,
    output logic                          o_clearing,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_status,
    output logic [ID_W-1:0]               o_out_id,
    output logic [GEN_BITS-1:0]           o_out_gen,
    output logic [ght_pkg::KIND_W-1:0]    o_out_kind,
    output logic [POS_W-1:0]              o_dense_pos
);

    localparam int KW    = ght_pkg::KIND_W;
    localparam int NF_W  = $clog2(MAX_IDS + 1);
    localparam int FS_AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int FT_W  = $clog2(FREE_DEPTH + 1);
    localparam int CNT_W = $clog2(KIND_DEPTH + 1);
    localparam int DN    = NUM_KINDS * KIND_DEPTH;
    localparam int DA_W  = (DN > 1) ? $clog2(DN) : 1;
    localparam int KI_W  = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int SL_W  = GEN_BITS + KW + 1;
    localparam int CW    = ((CNT_W > ght_pkg::CAP_W) ? CNT_W : ght_pkg::CAP_W) + 1;
    localparam int NLW   = ((NF_W > LW) ? NF_W : LW) + 1;

    ght_pkg::t_state r_state;
    ght_pkg::t_state n_state;

    logic [SL_W-1:0]  slot_mem  [MAX_IDS];
    logic [POS_W-1:0] pos_mem   [MAX_IDS];
    logic [ID_W-1:0]  dense_mem [DN];
    logic [ID_W-1:0]  stack_mem [FREE_DEPTH];

    logic [SL_W-1:0]  r_slot_q;
    logic [POS_W-1:0] r_pos_q;
    logic [ID_W-1:0]  r_dense_q;
    logic [ID_W-1:0]  r_stack_q;

    logic [ID_W-1:0]  r_clr;
    logic [FT_W-1:0]  r_free_top;
    logic [NF_W-1:0]  r_next_fresh;
    logic [CNT_W-1:0] r_count [NUM_KINDS];

    ght_pkg::t_cls    r_cls;
    logic [KW-1:0]    r_kind;
    logic [ID_W-1:0]  r_rid;
    logic [GEN_BITS-1:0] r_rgen;
    logic [ID_W-1:0]  r_aid;
    logic             r_use_stack;

    logic             r_out_valid;
    ght_pkg::t_status r_status;
    logic [ID_W-1:0]  r_oid;
    logic [GEN_BITS-1:0] r_ogen;
    logic [KW-1:0]    r_okind;
    logic [POS_W-1:0] r_opos;

    logic [KI_W-1:0]  w_kidx;
    logic [CNT_W-1:0] w_cnt;
    logic [ght_pkg::CAP_W-1:0] w_cap_raw;
    logic [CW-1:0]    w_cap;
    logic             w_kind_full;
    logic             w_no_free;
    logic             w_h_ok;
    logic             w_can_emit;
    logic             w_add_go;
    logic [ID_W-1:0]  w_add_id;
    logic [POS_W-1:0] w_last;
    logic [DA_W-1:0]  w_base;
    logic [NLW-1:0]   w_lim;

    logic [ID_W-1:0]  w_slot_ra;
    logic [DA_W-1:0]  w_dense_ra;
    logic [FS_AW-1:0] w_stack_ra;

    logic             slot_we;
    logic [ID_W-1:0]  slot_wa;
    logic [SL_W-1:0]  slot_wd;
    logic             pos_we;
    logic [ID_W-1:0]  pos_wa;
    logic [POS_W-1:0] pos_wd;
    logic             dense_we;
    logic [DA_W-1:0]  dense_wa;
    logic [ID_W-1:0]  dense_wd;
    logic             stack_we;
    logic             emit;
    ght_pkg::t_status e_status;
    logic [ID_W-1:0]  e_id;
    logic [GEN_BITS-1:0] e_gen;
    logic [POS_W-1:0] e_pos;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             q_pop;

    assign w_kidx    = r_kind[KI_W-1:0];
    assign w_cnt     = r_cls.kind_ok ? r_count[w_kidx] : '0;
    assign w_cap_raw = (r_kind < KW'(ght_pkg::NUM_CAPS)) ? i_cap[r_kind] : '0;
    assign w_cap     = (CW'(w_cap_raw) < CW'(KIND_DEPTH)) ? CW'(w_cap_raw) : CW'(KIND_DEPTH);
    assign w_kind_full = !r_cls.kind_ok || (CW'(w_cnt) >= w_cap);
    assign w_lim     = NLW'(i_lim);
    assign w_no_free = (r_free_top == '0) && (NLW'(r_next_fresh) >= w_lim);
    assign w_h_ok    = r_cls.id_ok && r_slot_q[SL_W-1]
                       && (r_slot_q[GEN_BITS-1:0] == r_rgen)
                       && (r_slot_q[GEN_BITS +: KW] == r_kind);
    assign w_add_id  = (r_free_top != '0) ? r_stack_q : r_next_fresh[ID_W-1:0];
    assign w_add_go  = (r_state == ght_pkg::S_EXEC) && r_cls.is_add
                       && !w_no_free && !w_kind_full;
    assign w_can_emit = !r_out_valid || i_ready;
    assign w_last    = POS_W'(w_cnt - CNT_W'(1));
    assign w_base    = DA_W'(w_kidx) * DA_W'(KIND_DEPTH);

    assign w_slot_ra  = ((r_state == ght_pkg::S_EXEC) && r_cls.is_add) ? w_add_id :
                        (r_state == ght_pkg::S_ADD) ? r_aid : r_rid;
    assign w_dense_ra = w_base + DA_W'(w_last);
    assign w_stack_ra = FS_AW'(r_free_top - FT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ght_pkg::S_CLEAR: begin
                if (r_clr == ID_W'(MAX_IDS - 1)) begin
                    n_state = ght_pkg::S_IDLE;
                end
            end
            ght_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = ght_pkg::S_READ;
                end
            end
            ght_pkg::S_READ: n_state = ght_pkg::S_EXEC;
            ght_pkg::S_EXEC: begin
                if (w_add_go) begin
                    n_state = ght_pkg::S_ADD;
                end else if (w_can_emit) begin
                    n_state = ght_pkg::S_IDLE;
                end
            end
            ght_pkg::S_ADD: begin
                if (w_can_emit) begin
                    n_state = ght_pkg::S_IDLE;
                end
            end
            default: n_state = ght_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        slot_we  = 1'b0;
        slot_wa  = r_rid;
        slot_wd  = {1'b0, r_slot_q[SL_W-2:0]};
        pos_we   = 1'b0;
        pos_wa   = r_dense_q;
        pos_wd   = r_pos_q;
        dense_we = 1'b0;
        dense_wa = w_base + DA_W'(r_pos_q);
        dense_wd = r_dense_q;
        stack_we = 1'b0;
        emit     = 1'b0;
        e_status = ght_pkg::ST_BAD;
        e_id     = r_rid;
        e_gen    = r_rgen;
        e_pos    = '0;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        q_pop    = 1'b0;
        unique case (r_state)
            ght_pkg::S_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = r_clr;
                slot_wd = '0;
            end
            ght_pkg::S_IDLE: q_pop = i_q_valid;
            ght_pkg::S_READ: q_pop = 1'b0;
            ght_pkg::S_EXEC: begin
                if (r_cls.is_add) begin
                    e_id  = '0;
                    e_gen = '0;
                    if (w_no_free) begin
                        emit     = w_can_emit;
                        e_status = ght_pkg::ST_NO_ID;
                    end else if (w_kind_full) begin
                        emit     = w_can_emit;
                        e_status = ght_pkg::ST_KIND_FULL;
                    end
                end else if (r_cls.is_del) begin
                    emit = w_can_emit;
                    if (!w_h_ok) begin
                        e_status = ght_pkg::ST_BAD;
                    end else if (r_free_top == FT_W'(FREE_DEPTH)) begin
                        e_status = ght_pkg::ST_STACK_FULL;
                    end else begin
                        e_status = ght_pkg::ST_OK;
                        e_pos    = r_pos_q;
                        slot_we  = w_can_emit;
                        dense_we = w_can_emit;
                        pos_we   = w_can_emit;
                        stack_we = w_can_emit;
                        cnt_dec  = w_can_emit;
                    end
                end else if (r_cls.is_look && w_h_ok) begin
                    emit     = w_can_emit;
                    e_status = ght_pkg::ST_OK;
                    e_pos    = r_pos_q;
                end else begin
                    emit = w_can_emit;
                end
            end
            ght_pkg::S_ADD: begin
                emit     = w_can_emit;
                e_status = ght_pkg::ST_OK;
                e_id     = r_aid;
                e_gen    = r_slot_q[GEN_BITS-1:0] + GEN_BITS'(1);
                e_pos    = POS_W'(w_cnt);
                slot_we  = w_can_emit;
                slot_wa  = r_aid;
                slot_wd  = {1'b1, r_kind, e_gen};
                pos_we   = w_can_emit;
                pos_wa   = r_aid;
                pos_wd   = POS_W'(w_cnt);
                dense_we = w_can_emit;
                dense_wa = w_base + DA_W'(w_cnt);
                dense_wd = r_aid;
                cnt_inc  = w_can_emit;
            end
            default: q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot_q  <= slot_mem[w_slot_ra];
        r_pos_q   <= pos_mem[r_rid];
        r_dense_q <= dense_mem[w_dense_ra];
        r_stack_q <= stack_mem[w_stack_ra];
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (dense_we) begin
            dense_mem[dense_wa] <= dense_wd;
        end
        if (stack_we) begin
            stack_mem[r_free_top[FS_AW-1:0]] <= r_rid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ght_pkg::S_CLEAR;
            r_clr        <= '0;
            r_free_top   <= '0;
            r_next_fresh <= '0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_count[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ght_pkg::S_CLEAR) begin
                r_clr <= r_clr + ID_W'(1);
            end
            for (int k = 0; k < NUM_KINDS; k++) begin
                if (w_kidx == KI_W'(k)) begin
                    if (cnt_inc) begin
                        r_count[k] <= w_cnt + CNT_W'(1);
                    end else if (cnt_dec) begin
                        r_count[k] <= w_cnt - CNT_W'(1);
                    end
                end
            end
            if (stack_we) begin
                r_free_top <= r_free_top + FT_W'(1);
            end else if (cnt_inc && r_use_stack) begin
                r_free_top <= r_free_top - FT_W'(1);
            end
            if (cnt_inc && !r_use_stack) begin
                r_next_fresh <= r_next_fresh + NF_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (q_pop) begin
            r_cls  <= i_q_cls;
            r_kind <= i_q_kind;
            r_rid  <= i_q_id;
            r_rgen <= i_q_gen;
        end
        if (w_add_go) begin
            r_aid       <= w_add_id;
            r_use_stack <= (r_free_top != '0);
        end
        if (emit) begin
            r_status <= e_status;
            r_oid    <= e_id;
            r_ogen   <= e_gen;
            r_okind  <= r_kind;
            r_opos   <= e_pos;
        end
    end

    assign o_q_pop     = q_pop;
    assign o_clearing  = (r_state == ght_pkg::S_CLEAR);
    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_out_id    = r_oid;
    assign o_out_gen   = r_ogen;
    assign o_out_kind  = r_okind;
    assign o_dense_pos = r_opos;

`ifndef SYNTH
    a_free_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_top <= FT_W'(FREE_DEPTH))
        else $error("free stack pointer overran");
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_fresh <= NF_W'(MAX_IDS))
        else $error("fresh id counter overran");
    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ght_pkg::S_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");
    a_delete_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stack_we && (r_state == ght_pkg::S_EXEC))
        |=> (r_free_top == $past(r_free_top) + FT_W'(1)))
        else $error("delete did not push freed id");
`endif

endmodule

[rtl/core/generational_handle_table.sv]
// Top level of the generational handle table: config registers and unit wiring.
//
// Requests enter on i_valid/o_ready (opcode, kind, req_id, req_gen); one
// result beat leaves per request on o_valid/i_ready, in request order.
// Add issues a handle from the LIFO free stack or the next fresh id and
// appends it to its kind's dense array; delete swap-removes a valid handle
// and frees its id; lookup returns the dense position of a valid handle.
// The intake stage and a two-entry queue feed the sequencer, so requests
// are taken while a result waits for the receiver.
// Lookup and delete go through the sequencer states idle (pop), read
// (the registered memory reads) and exec (check and write); add goes on
// to the add state, which uses one more read of the slot chosen from the
// free stack or fresh counter.
// After reset the slot table is swept clear, one entry a cycle; o_ready
// stays low meanwhile, configuration writes are taken.
// When the receiver stalls the result register holds, the sequencer waits
// and the queue fills until o_ready drops.
// Registers over APB: id_limit at 0x00, cap_type0..cap_type4 at 0x04..0x14.
module generational_handle_table #(
    parameter int MAX_IDS    = 2048,
    parameter int FREE_DEPTH = 128,
    parameter int KIND_DEPTH = 1024,
    parameter int GEN_BITS   = 8,
    parameter int NUM_KINDS  = 5,
    localparam int ID_W  = $clog2(MAX_IDS),
    localparam int POS_W = $clog2(KIND_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ght_pkg::ADDR_W-1:0]    paddr,
    input  logic [ght_pkg::DATA_W-1:0]    pwdata,
    output logic [ght_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ght_pkg::OP_W-1:0]      i_opcode,
    input  logic [ght_pkg::KIND_W-1:0]    i_kind,
    input  logic [ID_W-1:0]               i_req_id,
    input  logic [GEN_BITS-1:0]           i_req_gen,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_status,
    output logic [ID_W-1:0]               o_out_id,
    output logic [GEN_BITS-1:0]           o_out_gen,
    output logic [ght_pkg::KIND_W-1:0]    o_out_kind,
    output logic [POS_W-1:0]              o_dense_pos
);

    localparam int IDW2 = $clog2(MAX_IDS + 1);
    localparam int LW   = (IDW2 > ght_pkg::IDL_W) ? IDW2 : ght_pkg::IDL_W;
    localparam int CLS_W = $bits(ght_pkg::t_cls);
    localparam int QW   = CLS_W + ght_pkg::KIND_W + ID_W + GEN_BITS;

    logic [ght_pkg::IDL_W-1:0] r_id_limit;
    logic [ght_pkg::CAP_W-1:0] r_cap [ght_pkg::NUM_CAPS];
    logic [2:0]                w_idx;
    logic                      w_wr;
    logic [LW-1:0]             w_lim;

    logic                      w_clearing;
    logic                      w_front_ready;
    logic                      w_front_valid;
    ght_pkg::t_cls             w_f_cls;
    logic [ght_pkg::KIND_W-1:0] w_f_kind;
    logic [ID_W-1:0]           w_f_id;
    logic [GEN_BITS-1:0]       w_f_gen;
    logic                      w_q_ready;
    logic                      w_q_valid;
    logic                      w_q_pop;
    logic [QW-1:0]             w_q_data;
    ght_pkg::t_cls             w_q_cls;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_lim  = (LW'(r_id_limit) < LW'(MAX_IDS)) ? LW'(r_id_limit) : LW'(MAX_IDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_limit <= ght_pkg::RST_ID_LIMIT;
            for (int k = 0; k < ght_pkg::NUM_CAPS; k++) begin
                r_cap[k] <= ght_pkg::RST_CAP[k];
            end
        end else if (w_wr) begin
            unique case (w_idx) inside
                ght_pkg::REG_ID_LIMIT: r_id_limit <= pwdata[ght_pkg::IDL_W-1:0];
                ght_pkg::REG_CAP0, ght_pkg::REG_CAP1, ght_pkg::REG_CAP2,
                ght_pkg::REG_CAP3, ght_pkg::REG_CAP4: begin
                    r_cap[w_idx - ght_pkg::REG_CAP0] <= pwdata[ght_pkg::CAP_W-1:0];
                end
                default: r_id_limit <= r_id_limit;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx) inside
            ght_pkg::REG_ID_LIMIT: prdata = ght_pkg::DATA_W'(r_id_limit);
            ght_pkg::REG_CAP0, ght_pkg::REG_CAP1, ght_pkg::REG_CAP2,
            ght_pkg::REG_CAP3, ght_pkg::REG_CAP4: begin
                prdata = ght_pkg::DATA_W'(r_cap[w_idx - ght_pkg::REG_CAP0]);
            end
            default: prdata = '0;
        endcase
    end

    assign o_ready = w_front_ready && !w_clearing;

    ght_front #(
        .ID_W      (ID_W),
        .GEN_BITS  (GEN_BITS),
        .NUM_KINDS (NUM_KINDS),
        .LW        (LW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid && !w_clearing),
        .o_ready   (w_front_ready),
        .i_opcode  (i_opcode),
        .i_kind    (i_kind),
        .i_req_id  (i_req_id),
        .i_req_gen (i_req_gen),
        .i_lim     (w_lim),
        .o_valid   (w_front_valid),
        .i_ready   (w_q_ready),
        .o_cls     (w_f_cls),
        .o_kind    (w_f_kind),
        .o_id      (w_f_id),
        .o_gen     (w_f_gen)
    );

    ght_fifo #(
        .W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  ({w_f_cls, w_f_kind, w_f_id, w_f_gen}),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data)
    );

    assign w_q_cls = ght_pkg::t_cls'(w_q_data[QW-1 -: CLS_W]);

    ght_back #(
        .MAX_IDS    (MAX_IDS),
        .FREE_DEPTH (FREE_DEPTH),
        .KIND_DEPTH (KIND_DEPTH),
        .GEN_BITS   (GEN_BITS),
        .NUM_KINDS  (NUM_KINDS),
        .LW         (LW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lim       (w_lim),
        .i_cap       (r_cap),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_cls     (w_q_cls),
        .i_q_kind    (w_q_data[ID_W + GEN_BITS +: ght_pkg::KIND_W]),
        .i_q_id      (w_q_data[GEN_BITS +: ID_W]),
        .i_q_gen     (w_q_data[GEN_BITS-1:0]),
        .o_clearing  (w_clearing),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_out_gen   (o_out_gen),
        .o_out_kind  (o_out_kind),
        .o_dense_pos (o_dense_pos)
    );

endmodule
